FILE: rtl/core/calendar_clock_tick_defines.svh
// assertion macros for the calendar clock tick block
`ifndef CALENDAR_CLOCK_TICK_DEFINES_SVH
`define CALENDAR_CLOCK_TICK_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("calendar clock tick check failed");

// next-cycle implication, checked out of reset
`define CCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("calendar clock tick check failed");

`endif

FILE: rtl/core/cct_pkg.sv
// types, constants and calendar helper functions for the calendar clock tick block
`timescale 1ns / 1ps

package cct_pkg;

    localparam int YEAR_BITS = 16;

    localparam int SPT_W    = 8;
    localparam int SEC_W    = 6;
    localparam int MIN_W    = 6;
    localparam int HOUR_W   = 5;
    localparam int YEAR_W   = 16;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;

    localparam logic [SPT_W-1:0]     SPT_RESET    = 8'd1;
    localparam logic [YEAR_BITS-1:0] YEAR_RESET   = YEAR_BITS'(2017);
    localparam logic [MONTH_W-1:0]   MONTH_RESET  = 4'd11;
    localparam logic [DAY_W-1:0]     DAY_RESET    = 5'd13;
    localparam logic [HOUR_W-1:0]    HOUR_RESET   = 5'd9;
    localparam logic [MIN_W-1:0]     MINUTE_RESET = 6'd24;

    localparam logic [8:0] SECS_PER_MIN  = 9'd60;
    localparam logic [6:0] MINS_PER_HOUR = 7'd60;
    localparam logic [5:0] HOURS_PER_DAY = 6'd24;
    localparam logic [4:0] MONTH_LIMIT   = 5'd13;

    // exact divisibility by 25: y * inv(25) mod 2^32 <= (2^32 - 1) / 25
    localparam logic [31:0] INV25   = 32'hC28F_5C29;
    localparam logic [31:0] BOUND25 = 32'h0A3D_70A3;

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_LOAD = 1'b1
    } req_type_t;

    function automatic logic is_leap(input logic [YEAR_BITS-1:0] y);
        logic [31:0] prod;
        logic        div4;
        logic        div16;
        logic        div25;
        prod  = 32'(y) * INV25;
        div4  = (y[1:0] == 2'd0);
        div16 = (y[3:0] == 4'd0);
        div25 = (prod <= BOUND25);
        return div4 && (!div25 || div16);
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic              leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                                  len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:               len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
            4'd12:                                 len = 5'd31;
            default:                               len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/core/calendar_clock_tick.sv
// calendar clock tick: seconds, uptime and gregorian calendar counters
// an accepted word waits in the input register; its result word enters the result register once that is empty or taken
// throughput: one word per cycle while the output is not stalled, set by the combinational carry chain and leap check
// an input register and a result register give two words of buffering under stall
// reset (aresetn low, synchronous): buffers empty, counters to their start values
`timescale 1ns / 1ps
`include "calendar_clock_tick_defines.svh"

module calendar_clock_tick (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [cct_pkg::SPT_W-1:0]    cfg_wdata,     // seconds_per_tick
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [cct_pkg::S_DATA_W-1:0] s_tdata,       // load_year, load_month, load_day,
                                                        // load_hour, load_minute, zero pad
    input  logic                         s_tuser,       // req_type
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [cct_pkg::M_DATA_W-1:0] m_tdata        // uptime_seconds, uptime_minutes,
                                                        // uptime_hours, cal_year, cal_month,
                                                        // cal_day, cal_hour, cal_minute, pad
);
    import cct_pkg::*;

    logic [SPT_W-1:0]     spt_reg;

    logic                 in_valid_reg;
    req_type_t            in_type_reg;
    logic [YEAR_W-1:0]    in_year_reg;
    logic [MONTH_W-1:0]   in_month_reg;
    logic [DAY_W-1:0]     in_day_reg;
    logic [HOUR_W-1:0]    in_hour_reg;
    logic [MIN_W-1:0]     in_minute_reg;

    logic                 m_valid_reg;
    logic [M_DATA_W-1:0]  m_data_reg;
    logic [M_DATA_W-1:0]  m_data_next;

    logic [SEC_W-1:0]     sec_reg,     sec_next;
    logic [MIN_W-1:0]     up_min_reg,  up_min_next;
    logic [HOUR_W-1:0]    up_hour_reg, up_hour_next;
    logic [YEAR_BITS-1:0] year_reg,    year_next;
    logic [MONTH_W-1:0]   month_reg,   month_next;
    logic [DAY_W-1:0]     day_reg,     day_next;
    logic [HOUR_W-1:0]    hour_reg,    hour_next;
    logic [MIN_W-1:0]     minute_reg,  minute_next;

    logic                 advance;
    logic                 load_adv;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign load_adv = advance && (in_type_reg == REQ_LOAD);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // carry chain for one word
    always_comb begin
        logic [8:0]       sec_sum;
        logic [6:0]       up_min_inc;
        logic [5:0]       up_hour_inc;
        logic [6:0]       minute_inc;
        logic [5:0]       hour_inc;
        logic [DAY_W-1:0] len;
        logic [4:0]       month_inc;

        sec_next     = sec_reg;
        up_min_next  = up_min_reg;
        up_hour_next = up_hour_reg;
        year_next    = year_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;

        sec_sum     = 9'(sec_reg) + 9'(spt_reg);
        up_min_inc  = 7'(up_min_reg) + 7'd1;
        up_hour_inc = 6'(up_hour_reg) + 6'd1;
        minute_inc  = 7'(minute_reg) + 7'd1;
        hour_inc    = 6'(hour_reg) + 6'd1;
        month_inc   = 5'(month_reg) + 5'd1;
        len         = month_length(month_reg, is_leap(year_reg));

        if (in_type_reg == REQ_LOAD) begin
            year_next   = in_year_reg[YEAR_BITS-1:0];
            month_next  = in_month_reg;
            day_next    = in_day_reg;
            hour_next   = in_hour_reg;
            minute_next = in_minute_reg;
        end else if (sec_sum < SECS_PER_MIN) begin
            sec_next = sec_sum[SEC_W-1:0];
        end else begin
            sec_next = '0;
            // uptime clock
            if (up_min_inc < MINS_PER_HOUR) begin
                up_min_next = up_min_inc[MIN_W-1:0];
            end else begin
                up_min_next  = '0;
                up_hour_next = (up_hour_inc < HOURS_PER_DAY) ? up_hour_inc[HOUR_W-1:0] : '0;
            end
            // calendar
            if (minute_inc < MINS_PER_HOUR) begin
                minute_next = minute_inc[MIN_W-1:0];
            end else begin
                minute_next = '0;
                if (hour_inc < HOURS_PER_DAY) begin
                    hour_next = hour_inc[HOUR_W-1:0];
                end else begin
                    hour_next = '0;
                    if (day_reg < len) begin
                        day_next = day_reg + 5'd1;
                    end else begin
                        day_next = 5'd1;
                        if (month_inc < MONTH_LIMIT) begin
                            month_next = month_inc[MONTH_W-1:0];
                        end else begin
                            month_next = 4'd1;
                            year_next  = year_reg + YEAR_BITS'(1);
                        end
                    end
                end
            end
        end

        m_data_next = {3'd0, minute_next, hour_next, day_next, month_next,
                       YEAR_W'(year_next), up_hour_next, up_min_next, sec_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spt_reg <= SPT_RESET;
        end else if (cfg_we) begin
            spt_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_type_reg   <= req_type_t'(s_tuser);
            in_year_reg   <= s_tdata[15:0];
            in_month_reg  <= s_tdata[19:16];
            in_day_reg    <= s_tdata[24:20];
            in_hour_reg   <= s_tdata[29:25];
            in_minute_reg <= s_tdata[35:30];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_reg     <= '0;
            up_min_reg  <= '0;
            up_hour_reg <= '0;
            year_reg    <= YEAR_RESET;
            month_reg   <= MONTH_RESET;
            day_reg     <= DAY_RESET;
            hour_reg    <= HOUR_RESET;
            minute_reg  <= MINUTE_RESET;
        end else if (advance) begin
            sec_reg     <= sec_next;
            up_min_reg  <= up_min_next;
            up_hour_reg <= up_hour_next;
            year_reg    <= year_next;
            month_reg   <= month_next;
            day_reg     <= day_next;
            hour_reg    <= hour_next;
            minute_reg  <= minute_next;
        end
    end

    `CCT_ASSERT_NOW(a_sec_range, 1'b1, sec_reg < 6'd60)
    `CCT_ASSERT_NOW(a_uptime_range, 1'b1, (up_min_reg < 6'd60) && (up_hour_reg < 5'd24))
    `CCT_ASSERT_NOW(a_stall_cause, !s_tready, in_valid_reg && m_valid_reg && !m_tready)
    `CCT_ASSERT_NEXT(a_load_keeps_uptime, load_adv, $stable({sec_reg, up_min_reg, up_hour_reg}))
    `CCT_ASSERT_NEXT(a_result_follows, advance, m_valid_reg)

endmodule
